/* hw/rtl/tlvd_pkg.sv */
// Shared types and codes for the TLV stream deframer.
`default_nettype none
package tlvd_pkg;

   // Role of one payload byte within its element
   typedef enum logic [1:0] {
      ROLE_TYPE   = 2'd0,
      ROLE_LEN_LO = 2'd1,
      ROLE_LEN_HI = 2'd2,
      ROLE_VALUE  = 2'd3
   } role_type;

   // One parsed result
   typedef struct packed {
      role_type    byte_role;
      logic [7:0]  elem_type;
      logic [15:0] elem_length;
      logic [7:0]  value_byte;
      logic [15:0] value_index;
      logic        element_end;
      logic        payload_end;
      logic        truncated;
   } result_type;

endpackage
`default_nettype wire

/* hw/rtl/tlvd_req_if.sv */
// Input byte channel of the TLV stream deframer.
`default_nettype none
interface tlvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       payload_last;

   modport source (output valid, output data_byte, output payload_last, input ready);
   modport sink   (input valid, input data_byte, input payload_last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tlvd_rsp_if.sv */
// Result channel of the TLV stream deframer.
`default_nettype none
interface tlvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  byte_role;
   logic [7:0]  elem_type;
   logic [15:0] elem_length;
   logic [7:0]  value_byte;
   logic [15:0] value_index;
   logic        element_end;
   logic        payload_end;
   logic        truncated;

   modport source (output valid, output byte_role, output elem_type, output elem_length,
                   output value_byte, output value_index, output element_end,
                   output payload_end, output truncated, input ready);
   modport sink   (input valid, input byte_role, input elem_type, input elem_length,
                   input value_byte, input value_index, input element_end,
                   input payload_end, input truncated, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tlvd_parser.sv */
// Parse state and per-byte decode of type, length and value bytes.
`default_nettype none
module tlvd_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          data_byte,
   input  wire logic                payload_last,
   output tlvd_pkg::result_type     result
);
   import tlvd_pkg::*;

   role_type    phase_ff,  phase_in;
   logic [7:0]  type_ff,   type_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff,  count_in;

   logic [15:0] count_plus;
   logic        elem_end;
   role_type    next_phase;

   assign count_plus = count_ff + 16'd1;

   // Decode the current byte by phase
   always_comb begin
      type_in    = type_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      elem_end   = 1'b0;
      next_phase = ROLE_TYPE;
      result     = '0;
      result.byte_role   = phase_ff;
      result.payload_end = payload_last;
      unique case (phase_ff)
         ROLE_TYPE: begin
            type_in    = data_byte;
            length_in  = '0;
            next_phase = ROLE_LEN_LO;
         end
         ROLE_LEN_LO: begin
            length_in  = {8'd0, data_byte};
            next_phase = ROLE_LEN_HI;
         end
         ROLE_LEN_HI: begin
            length_in          = {data_byte, length_ff[7:0]};
            result.elem_length = length_in;
            count_in           = '0;
            elem_end           = (length_in == 16'd0);
            next_phase         = elem_end ? ROLE_TYPE : ROLE_VALUE;
         end
         ROLE_VALUE: begin
            result.elem_length = length_ff;
            result.value_byte  = data_byte;
            result.value_index = count_ff;
            count_in           = count_plus;
            elem_end           = (count_plus == length_ff);
            next_phase         = elem_end ? ROLE_TYPE : ROLE_VALUE;
         end
         default: begin
            next_phase = ROLE_TYPE;
         end
      endcase
      result.elem_type   = type_in;
      result.element_end = elem_end;
      result.truncated   = payload_last && !elem_end;
      phase_in = payload_last ? ROLE_TYPE : next_phase;
   end

   // State advances once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ROLE_TYPE;
         type_ff   <= '0;
         length_ff <= '0;
         count_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

   a_last_to_type: assert property (@(posedge clock) disable iff (reset)
      step && payload_last |=> phase_ff == ROLE_TYPE)
      else $error("phase not back to type after final byte");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == ROLE_VALUE |-> count_ff < length_ff)
      else $error("value index beyond element length");

   a_value_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == ROLE_LEN_HI && !payload_last && data_byte == 8'd0
      && length_ff[7:0] == 8'd0 |=> phase_ff == ROLE_TYPE)
      else $error("empty element entered value phase");

endmodule
`default_nettype wire

/* hw/rtl/tlv_stream_deframer.sv */
// TLV stream deframer top level: input register, byte parser, result register.
// Each accepted byte's result is registered once the result register is free or being drained.
// Throughput: 1 byte per cycle while rsp_chan is ready; the parser's phase update
// and one 16-bit counter compare sit between the input and result registers.
// Reset (synchronous, active high) empties both registers and sets the parser
// to expect a type byte with type, length and index cleared.
`default_nettype none
module tlv_stream_deframer (
   input  wire logic   clock,
   input  wire logic   reset,
   tlvd_req_if.sink    req_chan,
   tlvd_rsp_if.source  rsp_chan
);
   import tlvd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type parsed;
   logic       advance;
   logic       req_fire;

   // Input stage moves on when the result register is free or being drained
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   tlvd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .data_byte    (in_data_ff),
      .payload_last (in_last_ff),
      .result       (parsed)
   );

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.payload_last;
      end
      if (advance) begin
         out_ff <= parsed;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.byte_role   = out_ff.byte_role;
   assign rsp_chan.elem_type   = out_ff.elem_type;
   assign rsp_chan.elem_length = out_ff.elem_length;
   assign rsp_chan.value_byte  = out_ff.value_byte;
   assign rsp_chan.value_index = out_ff.value_index;
   assign rsp_chan.element_end = out_ff.element_end;
   assign rsp_chan.payload_end = out_ff.payload_end;
   assign rsp_chan.truncated   = out_ff.truncated;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("result overwritten while stalled");

   a_trunc_final: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.truncated |-> out_ff.payload_end && !out_ff.element_end)
      else $error("truncated result without final byte");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled input register lost its byte");

endmodule
`default_nettype wire

/* verif/tlv_stream_deframer_tb.sv */
// Self-checking testbench for the TLV stream deframer: random byte traffic, scoreboarded results.
module tlv_stream_deframer_tb;
   import tlvd_pkg::*;

   typedef logic [7:0] byte_q_type[$];

   localparam int RANDOM_ITEMS  = 1150;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 800000;

   logic clock = 1'b0;
   logic reset;

   tlvd_req_if req_chan ();
   tlvd_rsp_if rsp_chan ();

   tlv_stream_deframer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 12-unit clock period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Expected parser state, tracked per accepted byte
   role_type    exp_phase  = ROLE_TYPE;
   logic [7:0]  exp_type   = '0;
   logic [15:0] exp_length = '0;
   logic [15:0] exp_count  = '0;

   result_type  pending_results[$];
   result_type  oldest_result;
   int          fail_count = 0;
   int          items_sent = 0;
   int          cycle_count = 0;

   // Idle and stall controls
   bit          sender_idles    = 1'b1;
   bit          receiver_stalls = 1'b1;
   bit          hold_req = 1'b0;
   bit          hold_ack = 1'b0;
   int          hold_left  = 0;
   int          stall_left = 0;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 16'($urandom_range(0, 4));
      if (r < 90) return 16'($urandom_range(5, 16));
      return 16'($urandom_range(17, 64));
   endfunction

   // Work out the result of one byte and advance the expected parser state
   task automatic deframe_byte(input logic [7:0] data, input logic last);
      result_type r;
      role_type   nxt;
      r = '0;
      r.byte_role = exp_phase;
      nxt = ROLE_TYPE;
      case (exp_phase)
         ROLE_TYPE: begin
            exp_type = data;
            exp_length = '0;
            nxt = ROLE_LEN_LO;
         end
         ROLE_LEN_LO: begin
            exp_length = {8'h00, data};
            nxt = ROLE_LEN_HI;
         end
         ROLE_LEN_HI: begin
            exp_length = {data, exp_length[7:0]};
            r.elem_length = exp_length;
            exp_count = '0;
            if (exp_length == 16'd0) begin
               r.element_end = 1'b1;
            end else begin
               nxt = ROLE_VALUE;
            end
         end
         default: begin
            r.elem_length = exp_length;
            r.value_byte = data;
            r.value_index = exp_count;
            exp_count = exp_count + 16'd1;
            if (exp_count == exp_length) begin
               r.element_end = 1'b1;
            end else begin
               nxt = ROLE_VALUE;
            end
         end
      endcase
      r.elem_type = exp_type;
      r.payload_end = last;
      // a final byte always resyncs to a type byte
      if (last) begin
         r.truncated = !r.element_end;
         nxt = ROLE_TYPE;
      end
      exp_phase = nxt;
      pending_results.push_back(r);
   endtask

   // Offer one byte, wait for its transaction, then maybe idle
   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.payload_last <= last;
      do @(posedge clock); while (!req_chan.ready);
      deframe_byte(data, last);
      items_sent++;
      gap = sender_idles ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_payload(input byte_q_type bytes);
      for (int i = 0; i < bytes.size(); i++) begin
         send_byte(bytes[i], i == bytes.size() - 1);
      end
   endtask

   task automatic append_element(ref byte_q_type q, input logic [7:0] typ,
                                 input logic [15:0] len, input int n_values);
      q.push_back(typ);
      q.push_back(len[7:0]);
      q.push_back(len[15:8]);
      repeat (n_values) q.push_back(8'($urandom));
   endtask

   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Extremes of the fields, zero length, and each way a payload can end early
   task automatic test_directed();
      send_payload({8'h00, 8'h00, 8'h00});
      send_payload({8'hFF, 8'h02, 8'h00, 8'h00, 8'hFF});
      send_payload({8'h00, 8'h00, 8'h00, 8'h5A, 8'h01, 8'h00, 8'h80, 8'h11});
      send_payload({8'h22, 8'h34});
      send_payload({8'h33, 8'h01, 8'h80});
      send_payload({8'h44, 8'hFF, 8'hFF, 8'hAA});
   endtask

   // Receiver holds off while the sender keeps offering bytes
   task automatic test_output_hold();
      byte_q_type q;
      q = {};
      sender_idles = 1'b0;
      hold_req <= ~hold_req;
      while (q.size() < 40) append_element(q, 8'($urandom), 16'd9, 9);
      send_payload(q);
      sender_idles = 1'b1;
   endtask

   // Sender stops until every result is back, a few times over
   task automatic test_sender_pause();
      byte_q_type q;
      logic [15:0] len;
      repeat (3) begin
         q = {};
         repeat ($urandom_range(1, 3)) begin
            len = pick_length();
            append_element(q, 8'($urandom), len, len);
         end
         send_payload(q);
         wait_results_drained();
      end
   endtask

   // Mostly well-formed payloads, some cut short, some raw noise
   task automatic test_random_traffic();
      byte_q_type q;
      byte_q_type part;
      logic [15:0] len;
      int kind;
      int keep;
      int n;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            sender_idles = $urandom_range(0, 1);
            receiver_stalls <= $urandom_range(0, 1);
         end
         kind = $urandom_range(0, 99);
         if (kind < 90) begin
            q = {};
            repeat ($urandom_range(1, 4)) begin
               len = pick_length();
               append_element(q, 8'($urandom), len, len);
            end
            // payload ends inside a header or a value
            if (kind >= 75) begin
               part = {};
               len = ($urandom_range(0, 2) == 0) ? 16'($urandom) : pick_length();
               append_element(part, 8'($urandom), len, (len < 7) ? int'(len) : 7);
               keep = $urandom_range(1, part.size());
               if (keep == int'(len) + 3) keep--;
               for (int i = 0; i < keep; i++) q.push_back(part[i]);
            end
            send_payload(q);
         end else begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
               send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 5) == 0));
            end
         end
      end
      sender_idles = 1'b1;
      receiver_stalls <= 1'b1;
   endtask

   // Largest length field, payload cut off after a few value bytes
   task automatic test_max_length();
      byte_q_type q;
      q = {};
      sender_idles = 1'b0;
      receiver_stalls <= 1'b0;
      append_element(q, 8'($urandom), 16'hFFFF, 8);
      send_payload(q);
      sender_idles = 1'b1;
      receiver_stalls <= 1'b1;
   endtask

   // Result ready: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
         rsp_chan.ready <= 1'b0;
         stall_left = pick_gap();
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      end
   endtask

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            $error("result with no expectation pending");
         end else begin
            oldest_result = pending_results.pop_front();
            compare_field("byte_role", oldest_result.byte_role, rsp_chan.byte_role);
            compare_field("elem_type", oldest_result.elem_type, rsp_chan.elem_type);
            compare_field("elem_length", oldest_result.elem_length, rsp_chan.elem_length);
            compare_field("value_byte", oldest_result.value_byte, rsp_chan.value_byte);
            compare_field("value_index", oldest_result.value_index, rsp_chan.value_index);
            compare_field("element_end", oldest_result.element_end, rsp_chan.element_end);
            compare_field("payload_end", oldest_result.payload_end, rsp_chan.payload_end);
            compare_field("truncated", oldest_result.truncated, rsp_chan.truncated);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tlv_stream_deframer test failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.payload_last = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_output_hold();
      test_sender_pause();
      test_random_traffic();
      test_max_length();

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("tlv_stream_deframer test passed");
      end else begin
         $display("tlv_stream_deframer test failed");
      end
      $finish;
   end

endmodule
